[rtl/dttf_pkg.sv]
// shared types, constants and tables of the decimal text to fixed-point parser
package dttf_pkg;

    localparam int unsigned MAX_CHARS = 256;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned INT_W   = 31;
    localparam int unsigned FRAC_W  = 32;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned PLACE_W = 4;

    localparam logic [COUNT_W-1:0] COUNT_TOP  = '1;
    localparam logic [PLACE_W-1:0] PLACE_NONE = PLACE_W'(0);
    localparam logic [PLACE_W-1:0] PLACE_TOP  = PLACE_W'(10);
    localparam logic [INT_W:0]     INT_MAX    = {1'b0, {INT_W{1'b1}}};

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LONG  = 2'd1,
        ST_SATURATED = 2'd2
    } t_status;

    typedef struct packed {
        logic       is_digit;
        logic [3:0] digit;
        logic       is_minus;
        logic       is_point;
        logic       is_plus;
    } t_char_class;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      is_number;
        t_status                   status;
    } t_result;

    // floor(2^32 / 10^k) for fraction digit k
    function automatic logic [FRAC_W-1:0] frac_weight(input logic [PLACE_W-1:0] place);
        logic [FRAC_W-1:0] w;
        case (place)
            4'd1:    w = 32'd429496729;
            4'd2:    w = 32'd42949672;
            4'd3:    w = 32'd4294967;
            4'd4:    w = 32'd429496;
            4'd5:    w = 32'd42949;
            4'd6:    w = 32'd4294;
            4'd7:    w = 32'd429;
            4'd8:    w = 32'd42;
            4'd9:    w = 32'd4;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

[rtl/decimal_text_to_fixed_parser.sv]
// top level of the decimal text to signed q31.32 parser
//
//  channel | valid   | stall    | payload
//  --------+---------+----------+---------------------------------------
//  input   | i_valid | o_stall  | i_character[7:0], i_last
//  result  | o_valid | i_stall  | o_value[63:0], o_is_number, o_status[1:0]
//
// one character per cycle unless o_stall holds it; the path from a character to
// its result runs through the input register and the result register around the
// single update stage
// synchronous active-low reset clears the parse state and both valid bits
// a stalled result holds only characters marked last; others keep flowing
module decimal_text_to_fixed_parser #(
    parameter int unsigned MAX_CHARS = dttf_pkg::MAX_CHARS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [dttf_pkg::CHAR_W-1:0]          i_character,
    input  logic                                 i_last,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [dttf_pkg::VALUE_W-1:0]  o_value,
    output logic                                 o_is_number,
    output logic [1:0]                           o_status
);

    logic                        r_in_valid;
    logic [dttf_pkg::CHAR_W-1:0] r_in_char;
    logic                        r_in_last;
    logic                        r_out_valid;
    dttf_pkg::t_result           r_out;

    dttf_pkg::t_char_class char_class;
    dttf_pkg::t_result     result;
    logic                  out_free;
    logic                  step;
    logic                  in_take;

    assign out_free = !r_out_valid || !i_stall;
    assign step     = r_in_valid && (!r_in_last || out_free);
    assign o_stall  = r_in_valid && !step;
    assign in_take  = i_valid && !o_stall;

    dttf_classify u_classify (
        .i_character (r_in_char),
        .o_class     (char_class)
    );

    dttf_accum #(
        .MAX_CHARS (MAX_CHARS)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_last   (r_in_last),
        .i_class  (char_class),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !step);
            if (step && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_character;
            r_in_last <= i_last;
        end
        if (step && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value     = r_out.value;
    assign o_is_number = r_out.is_number;
    assign o_status    = r_out.status;

endmodule

[rtl/dttf_classify.sv]
// character classifier: digit value and sign, point and plus detection
module dttf_classify (
    input  logic [dttf_pkg::CHAR_W-1:0] i_character,
    output dttf_pkg::t_char_class       o_class
);

    logic [dttf_pkg::CHAR_W-1:0] offset;

    assign offset = i_character - dttf_pkg::CH_ZERO;

    always_comb begin
        o_class.is_digit = (i_character >= dttf_pkg::CH_ZERO) &&
                           (i_character <= dttf_pkg::CH_NINE);
        o_class.digit    = offset[3:0];
        o_class.is_minus = (i_character == dttf_pkg::CH_MINUS);
        o_class.is_point = (i_character == dttf_pkg::CH_POINT);
        o_class.is_plus  = (i_character == dttf_pkg::CH_PLUS);
    end

endmodule

[rtl/dttf_accum.sv]
// running parse state: q31.32 magnitude, counters, flags and the final result
module dttf_accum #(
    parameter int unsigned MAX_CHARS = dttf_pkg::MAX_CHARS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_last,
    input  dttf_pkg::t_char_class i_class,
    output dttf_pkg::t_result     o_result
);

    logic [dttf_pkg::INT_W-1:0]   r_int,   n_int;
    logic [dttf_pkg::FRAC_W-1:0]  r_frac,  n_frac;
    logic [dttf_pkg::COUNT_W-1:0] r_count, n_count;
    logic [dttf_pkg::PLACE_W-1:0] r_place, n_place;
    logic r_neg,  n_neg;
    logic r_plus, n_plus;
    logic r_inv,  n_inv;
    logic r_ovf,  n_ovf;

    logic [dttf_pkg::INT_W+3:0]  int_next;
    logic [dttf_pkg::FRAC_W+3:0] frac_prod;
    logic [dttf_pkg::VALUE_W-1:0] mag;

    assign int_next = ({4'b0, r_int} << 3) + ({4'b0, r_int} << 1)
                    + (dttf_pkg::INT_W+4)'(i_class.digit);
    assign frac_prod = (dttf_pkg::FRAC_W+4)'(i_class.digit)
                     * {4'b0, dttf_pkg::frac_weight(r_place)};

    always_comb begin
        n_int   = r_int;
        n_frac  = r_frac;
        n_place = r_place;
        n_neg   = r_neg;
        n_plus  = r_plus;
        n_inv   = r_inv;
        n_ovf   = r_ovf;
        if (!r_inv) begin
            if (i_class.is_digit) begin
                if (!r_ovf) begin
                    if (r_place == dttf_pkg::PLACE_NONE) begin
                        if (int_next > (dttf_pkg::INT_W+4)'(dttf_pkg::INT_MAX)) begin
                            n_int  = '1;
                            n_frac = '1;
                            n_ovf  = 1'b1;
                        end else begin
                            n_int = int_next[dttf_pkg::INT_W-1:0];
                        end
                    end else if (r_place < dttf_pkg::PLACE_TOP) begin
                        n_frac  = r_frac + frac_prod[dttf_pkg::FRAC_W-1:0];
                        n_place = r_place + 1'b1;
                    end
                end
            end else if (i_class.is_minus && (r_count == '0)) begin
                n_neg = 1'b1;
            end else if (i_class.is_point && (r_place == dttf_pkg::PLACE_NONE)) begin
                n_place = dttf_pkg::PLACE_W'(1);
            end else if (i_class.is_plus && !r_plus) begin
                n_plus = 1'b1;
            end else begin
                n_inv = 1'b1;
            end
        end
        n_count = (r_count == dttf_pkg::COUNT_TOP) ? r_count : r_count + 1'b1;
    end

    assign mag = {1'b0, n_int, n_frac};

    always_comb begin
        o_result.value     = '0;
        o_result.is_number = 1'b0;
        o_result.status    = dttf_pkg::ST_OK;
        if (n_count >= dttf_pkg::COUNT_W'(MAX_CHARS)) begin
            o_result.status = dttf_pkg::ST_TOO_LONG;
        end else if (!n_inv) begin
            o_result.is_number = 1'b1;
            o_result.value     = n_neg ? -mag : mag;
            if (n_ovf) begin
                o_result.status = dttf_pkg::ST_SATURATED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_int   <= '0;
            r_frac  <= '0;
            r_count <= '0;
            r_place <= dttf_pkg::PLACE_NONE;
            r_neg   <= 1'b0;
            r_plus  <= 1'b0;
            r_inv   <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_step) begin
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_count <= n_count;
            r_place <= n_place;
            r_neg   <= n_neg;
            r_plus  <= n_plus;
            r_inv   <= n_inv;
            r_ovf   <= n_ovf;
        end
    end

endmodule

[bench/testbench.sv]
// self-checking testbench of the decimal text to q31.32 parser
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum {TXT_NUMBER, TXT_BIG, TXT_BROKEN, TXT_NOISE} t_text_kind;
    typedef enum {SINK_FREE, SINK_LIGHT, SINK_HEAVY} t_sink_mode;

    typedef struct packed {
        logic [dttf_pkg::CHAR_W-1:0] ch;
        logic                        last;
        logic                        typed;
        dttf_pkg::t_result           res;
    } t_dir_row;

    localparam dttf_pkg::t_result NO_RESULT = '0;
    localparam int N_DIRECTED = 20;
    localparam t_dir_row DIRECTED [N_DIRECTED] = '{
        '{"7",                1'b1, 1'b1, '{64'h0000_0007_0000_0000, 1'b1, dttf_pkg::ST_OK}},
        '{dttf_pkg::CH_MINUS, 1'b1, 1'b1, '{64'h0, 1'b1, dttf_pkg::ST_OK}},
        '{dttf_pkg::CH_PLUS,  1'b1, 1'b1, '{64'h0, 1'b1, dttf_pkg::ST_OK}},
        '{dttf_pkg::CH_POINT, 1'b1, 1'b1, '{64'h0, 1'b1, dttf_pkg::ST_OK}},
        '{8'h00,              1'b1, 1'b1, '{64'h0, 1'b0, dttf_pkg::ST_OK}},
        '{8'hff,              1'b1, 1'b1, '{64'h0, 1'b0, dttf_pkg::ST_OK}},
        '{"1",                1'b0, 1'b0, NO_RESULT},
        '{dttf_pkg::CH_POINT, 1'b0, 1'b0, NO_RESULT},
        '{"5",                1'b1, 1'b0, NO_RESULT},
        '{dttf_pkg::CH_PLUS,  1'b0, 1'b0, NO_RESULT},
        '{dttf_pkg::CH_MINUS, 1'b1, 1'b1, '{64'h0, 1'b0, dttf_pkg::ST_OK}},
        '{dttf_pkg::CH_POINT, 1'b0, 1'b0, NO_RESULT},
        '{dttf_pkg::CH_POINT, 1'b1, 1'b1, '{64'h0, 1'b0, dttf_pkg::ST_OK}},
        '{dttf_pkg::CH_MINUS, 1'b0, 1'b0, NO_RESULT},
        '{dttf_pkg::CH_POINT, 1'b0, 1'b0, NO_RESULT},
        '{"9",                1'b1, 1'b0, NO_RESULT},
        '{dttf_pkg::CH_PLUS,  1'b0, 1'b0, NO_RESULT},
        '{dttf_pkg::CH_PLUS,  1'b1, 1'b1, '{64'h0, 1'b0, dttf_pkg::ST_OK}},
        '{dttf_pkg::CH_MINUS, 1'b0, 1'b0, NO_RESULT},
        '{"7",                1'b1, 1'b1, '{64'hffff_fff9_0000_0000, 1'b1, dttf_pkg::ST_OK}}
    };

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic [dttf_pkg::CHAR_W-1:0]         i_character;
    logic                                i_last;
    logic                                o_valid;
    logic                                i_stall;
    logic signed [dttf_pkg::VALUE_W-1:0] o_value;
    logic                                o_is_number;
    logic [1:0]                          o_status;

    decimal_text_to_fixed_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_character (i_character),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value     (o_value),
        .o_is_number (o_is_number),
        .o_status    (o_status)
    );

    // running parse state of the text being received
    logic [dttf_pkg::VALUE_W-1:0] num_mag;
    logic [dttf_pkg::COUNT_W-1:0] num_count;
    logic [dttf_pkg::COUNT_W-1:0] num_place;
    logic                         num_neg;
    logic                         num_plus;
    logic                         num_bad;
    logic                         num_sat;

    dttf_pkg::t_result pending_numbers [$];
    dttf_pkg::t_result want;
    logic [7:0]        text_buf [$];
    int                mismatches;
    int                items_sent;
    bit                tight;
    bit                hold_request;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    task automatic parse_char(input logic [7:0] c, input logic l,
                              output logic done, output dttf_pkg::t_result r);
        logic [dttf_pkg::VALUE_W-1:0] int_part;
        logic [dttf_pkg::VALUE_W-1:0] weight;
        logic [3:0]                   d;
        done = 1'b0;
        r = NO_RESULT;
        r.status = dttf_pkg::ST_OK;
        if (!num_bad) begin
            if (c >= dttf_pkg::CH_ZERO && c <= dttf_pkg::CH_NINE) begin
                d = 4'(c - dttf_pkg::CH_ZERO);
                if (!num_sat) begin
                    if (num_place == '0) begin
                        int_part = (num_mag >> 32) * 10 + dttf_pkg::VALUE_W'(d);
                        if (int_part > 64'h7fff_ffff) begin
                            num_mag = 64'h7fff_ffff_ffff_ffff;
                            num_sat = 1'b1;
                        end else begin
                            num_mag = {int_part[31:0], num_mag[31:0]};
                        end
                    end else begin
                        if (num_place < 10) begin
                            weight = 1;
                            repeat (num_place) weight = weight * 10;
                            weight = 64'h1_0000_0000 / weight;
                            num_mag = num_mag + dttf_pkg::VALUE_W'(d) * weight;
                        end
                        if (num_place != '1) num_place = num_place + 1'b1;
                    end
                end
            end else if (c == dttf_pkg::CH_MINUS && num_count == '0) begin
                num_neg = 1'b1;
            end else if (c == dttf_pkg::CH_POINT && num_place == '0) begin
                num_place = 1;
            end else if (c == dttf_pkg::CH_PLUS && !num_plus) begin
                num_plus = 1'b1;
            end else begin
                num_bad = 1'b1;
            end
        end
        if (num_count != '1) num_count = num_count + 1'b1;
        if (l) begin
            done = 1'b1;
            if (num_count >= dttf_pkg::MAX_CHARS) begin
                r.status = dttf_pkg::ST_TOO_LONG;
            end else if (!num_bad) begin
                r.is_number = 1'b1;
                r.value = num_neg ? 64'h0 - num_mag : num_mag;
                if (num_sat) r.status = dttf_pkg::ST_SATURATED;
            end
            num_mag = '0;
            num_count = '0;
            num_place = '0;
            num_neg = 1'b0;
            num_plus = 1'b0;
            num_bad = 1'b0;
            num_sat = 1'b0;
        end
    endtask

    task automatic put_char(input logic [7:0] c, input logic l,
                            input logic typed, input dttf_pkg::t_result typed_res);
        int                gap;
        int                roll;
        logic              done;
        dttf_pkg::t_result r;
        roll = $urandom_range(0, 99);
        if (tight || roll < 65) gap = 0;
        else if (roll < 90) gap = $urandom_range(1, 2);
        else if (roll < 98) gap = $urandom_range(3, 6);
        else gap = $urandom_range(10, 30);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_character <= c;
        i_last <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        parse_char(c, l, done, r);
        if (done) pending_numbers.push_back(typed ? typed_res : r);
        items_sent++;
    endtask

    task automatic send_text();
        for (int k = 0; k < text_buf.size(); k++)
            put_char(text_buf[k], k == text_buf.size() - 1, 1'b0, NO_RESULT);
    endtask

    task automatic make_text(input t_text_kind kind);
        string digits;
        text_buf.delete();
        case (kind)
            TXT_NUMBER, TXT_BROKEN: begin
                if ($urandom_range(0, 2) == 0) text_buf.push_back(dttf_pkg::CH_MINUS);
                repeat ($urandom_range(0, 10))
                    text_buf.push_back(8'(dttf_pkg::CH_ZERO + $urandom_range(0, 9)));
                if ($urandom_range(0, 1)) begin
                    text_buf.push_back(dttf_pkg::CH_POINT);
                    repeat ($urandom_range(0, 12))
                        text_buf.push_back(8'(dttf_pkg::CH_ZERO + $urandom_range(0, 9)));
                end
                if ($urandom_range(0, 3) == 0)
                    text_buf.insert($urandom_range(0, text_buf.size()), dttf_pkg::CH_PLUS);
                if (kind == TXT_BROKEN) begin
                    if (text_buf.size() == 0 || $urandom_range(0, 1)) begin
                        case ($urandom_range(0, 3))
                            0: text_buf.push_back(dttf_pkg::CH_POINT);
                            1: text_buf.push_back(dttf_pkg::CH_PLUS);
                            2: text_buf.push_back(dttf_pkg::CH_MINUS);
                            default: text_buf.push_back(8'($urandom_range(0, 255)));
                        endcase
                    end else begin
                        text_buf[$urandom_range(0, text_buf.size() - 1)] =
                            8'($urandom_range(0, 255));
                    end
                end
            end
            TXT_BIG: begin
                if ($urandom_range(0, 1)) text_buf.push_back(dttf_pkg::CH_MINUS);
                if ($urandom_range(0, 1)) begin
                    digits = $sformatf("%0d", 64'd2147483640 + 64'($urandom_range(0, 15)));
                    foreach (digits[k]) text_buf.push_back(digits[k]);
                end else begin
                    text_buf.push_back(8'(dttf_pkg::CH_ZERO + $urandom_range(1, 9)));
                    repeat ($urandom_range(9, 11))
                        text_buf.push_back(8'(dttf_pkg::CH_ZERO + $urandom_range(0, 9)));
                end
                if ($urandom_range(0, 1)) begin
                    text_buf.push_back(dttf_pkg::CH_POINT);
                    repeat ($urandom_range(1, 4))
                        text_buf.push_back(8'(dttf_pkg::CH_ZERO + $urandom_range(0, 9)));
                end
            end
            default: begin
                repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        if (text_buf.size() == 0)
            text_buf.push_back(8'(dttf_pkg::CH_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic make_long(input int len, input logic spoil);
        text_buf.delete();
        text_buf.push_back("1");
        text_buf.push_back(dttf_pkg::CH_POINT);
        while (text_buf.size() < len)
            text_buf.push_back(8'(dttf_pkg::CH_ZERO + $urandom_range(0, 9)));
        if (spoil) text_buf[$urandom_range(2, len - 1)] = 8'($urandom_range(8'h3a, 8'h7f));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_numbers.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result: value %h is_number %b status %0d",
                         $time, o_value, o_is_number, o_status);
            end else begin
                want = pending_numbers.pop_front();
                if (o_value !== want.value) begin
                    mismatches++;
                    $display("%0t value mismatch: expected %h actual %h",
                             $time, want.value, o_value);
                end
                if (o_is_number !== want.is_number) begin
                    mismatches++;
                    $display("%0t is_number mismatch: expected %b actual %b",
                             $time, want.is_number, o_is_number);
                end
                if (o_status !== want.status) begin
                    mismatches++;
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, want.status, o_status);
                end
            end
        end
    end

    initial begin : result_sink
        t_sink_mode mode;
        int         span;
        i_stall = 1'b0;
        mode = SINK_FREE;
        span = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (60) @(negedge i_clk);
                hold_request = 1'b0;
                i_stall <= 1'b0;
            end else begin
                if (span == 0) begin
                    mode = t_sink_mode'($urandom_range(0, 2));
                    span = $urandom_range(20, 200);
                end
                span--;
                case (mode)
                    SINK_FREE: i_stall <= 1'b0;
                    SINK_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    default: begin
                        if ($urandom_range(0, 24) == 0) begin
                            i_stall <= 1'b1;
                            repeat ($urandom_range(5, 40)) @(negedge i_clk);
                            i_stall <= 1'b0;
                        end else begin
                            i_stall <= 1'($urandom_range(0, 1));
                        end
                    end
                endcase
            end
        end
    end

    initial begin : stimulus
        int         text_no;
        int         roll;
        t_text_kind kind;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_character = '0;
        i_last = 1'b0;
        mismatches = 0;
        items_sent = 0;
        tight = 1'b0;
        hold_request = 1'b0;
        num_mag = '0;
        num_count = '0;
        num_place = '0;
        num_neg = 1'b0;
        num_plus = 1'b0;
        num_bad = 1'b0;
        num_sat = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++)
            put_char(DIRECTED[k].ch, DIRECTED[k].last, DIRECTED[k].typed, DIRECTED[k].res);

        text_no = 0;
        while (items_sent < 1100) begin
            text_no++;
            if (text_no == 20) begin
                // receiver holds off while short texts keep coming
                hold_request = 1'b1;
                tight = 1'b1;
                repeat (30) begin
                    make_text(TXT_NOISE);
                    if (text_buf.size() > 2) text_buf = text_buf[0:1];
                    send_text();
                end
            end else if (text_no == 40 || text_no == 80) begin
                make_long(text_no == 40 ? dttf_pkg::MAX_CHARS - 1 : dttf_pkg::MAX_CHARS,
                          text_no == 80);
                send_text();
            end else begin
                tight = ($urandom_range(0, 4) == 0);
                roll = $urandom_range(0, 99);
                if (roll < 55) kind = TXT_NUMBER;
                else if (roll < 67) kind = TXT_BIG;
                else if (roll < 85) kind = TXT_BROKEN;
                else kind = TXT_NOISE;
                make_text(kind);
                send_text();
            end
        end
        tight = 1'b0;
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (pending_numbers.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
